/* design/hid_key_to_ascii_translator_assert.svh */
// ----------------------------------------------------------------------------
// hid key translator assertion macros
// concurrent checks sampled on the rising clock edge, held off during reset
// ----------------------------------------------------------------------------
`ifndef HID_KEY_TO_ASCII_TRANSLATOR_ASSERT_SVH
`define HID_KEY_TO_ASCII_TRANSLATOR_ASSERT_SVH

// same-cycle implication
`define HK2A_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HK2A_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/hk2a_pkg.sv */
// ----------------------------------------------------------------------------
// hk2a_pkg
// beat types, action codes, keycodes and us-layout character tables
// ----------------------------------------------------------------------------
package hk2a_pkg;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic [3:0] action;
      logic [6:0] ascii_char;
      logic       caps_active;
   } rsp_type;

   localparam logic [3:0] ACT_NONE      = 4'd0;
   localparam logic [3:0] ACT_CHAR      = 4'd1;
   localparam logic [3:0] ACT_BACKSPACE = 4'd2;
   localparam logic [3:0] ACT_ENTER     = 4'd3;
   localparam logic [3:0] ACT_TAB       = 4'd4;
   localparam logic [3:0] ACT_DELETE    = 4'd5;
   localparam logic [3:0] ACT_LEFT      = 4'd6;
   localparam logic [3:0] ACT_RIGHT     = 4'd7;
   localparam logic [3:0] ACT_UP        = 4'd8;
   localparam logic [3:0] ACT_DOWN      = 4'd9;
   localparam logic [3:0] ACT_UNHANDLED = 4'd10;

   localparam logic [7:0] KEY_NONE      = 8'h00;
   localparam logic [7:0] KEY_A         = 8'h04;
   localparam logic [7:0] KEY_Z         = 8'h1D;
   localparam logic [7:0] KEY_1         = 8'h1E;
   localparam logic [7:0] KEY_0         = 8'h27;
   localparam logic [7:0] KEY_ENTER     = 8'h28;
   localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
   localparam logic [7:0] KEY_TAB       = 8'h2B;
   localparam logic [7:0] KEY_SPACE     = 8'h2C;
   localparam logic [7:0] KEY_SLASH     = 8'h38;
   localparam logic [7:0] KEY_CAPS      = 8'h39;
   localparam logic [7:0] KEY_DELETE    = 8'h4C;
   localparam logic [7:0] KEY_RIGHT     = 8'h4F;
   localparam logic [7:0] KEY_LEFT      = 8'h50;
   localparam logic [7:0] KEY_DOWN      = 8'h51;
   localparam logic [7:0] KEY_UP        = 8'h52;

   localparam logic [7:0] SHIFT_MASK    = 8'h22;

   localparam logic [6:0] CHAR_UPPER_A  = 7'h41;
   localparam logic [6:0] CHAR_LOWER_A  = 7'h61;
   localparam logic [6:0] CHAR_NUL      = 7'h00;

   localparam logic [6:0] DIGIT_PLAIN [0:9] = '{
      7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
   };
   localparam logic [6:0] DIGIT_SHIFT [0:9] = '{
      7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
   };
   // hole at the non-us hash key
   localparam logic [6:0] PUNCT_PLAIN [0:12] = '{
      7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h00,
      7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
   };
   localparam logic [6:0] PUNCT_SHIFT [0:12] = '{
      7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h00,
      7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
   };

endpackage

/* design/hid_key_to_ascii_translator.sv */
// ----------------------------------------------------------------------------
// hid_key_to_ascii_translator
// usb hid key report to us-layout ascii with sticky capslock
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+----------------------------------
//   req     | in        | req_valid/req_stall | modifier_bits, key_code
//   rsp     | out       | rsp_valid/rsp_stall | action, ascii_char, caps_active
//
// one report per clock while rsp_stall is low; a req beat passes the input
// register, then the decode logic and the result register, to the rsp beat
// reset clears both valid flags and capslock; payload registers are not reset
// req_stall rises only while the input register is full and the result
// register holds a stalled beat
// ----------------------------------------------------------------------------
module hid_key_to_ascii_translator
   import hk2a_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

`include "hid_key_to_ascii_translator_assert.svh"

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   logic    caps_ff, caps_in;
   rsp_type dec_rsp;
   logic    out_free;
   logic    s1_move;
   logic    req_accept;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign s1_move    = s1_valid_ff & out_free;
   assign req_stall  = s1_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;

   hk2a_decode u_decode (
      .req       (s1_req_ff),
      .caps_lock (caps_ff),
      .rsp       (dec_rsp)
   );

   always_comb begin
      s1_valid_in  = req_accept | (s1_valid_ff & ~s1_move);
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      caps_in      = s1_move ? dec_rsp.caps_active : caps_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         caps_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         caps_ff      <= caps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      if (s1_move) begin
         rsp_ff <= dec_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `HK2A_ASSERT_IMP(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff, "stall with empty input stage")
   `HK2A_ASSERT_NXT(a_caps_toggle, clock, reset, s1_move && (s1_req_ff.key_code == KEY_CAPS), caps_ff != $past(caps_ff), "capslock did not toggle")
   `HK2A_ASSERT_IMP(a_caps_matches, clock, reset, rsp_valid_ff, rsp_ff.caps_active == caps_ff, "result capslock out of step")
   `HK2A_ASSERT_IMP(a_char_consistent, clock, reset, rsp_valid_ff, (rsp_ff.action == ACT_CHAR) == (rsp_ff.ascii_char != CHAR_NUL), "character and action disagree")

endmodule

/* design/hk2a_char_lut.sv */
// ----------------------------------------------------------------------------
// hk2a_char_lut
// us-layout character lookup for letters, digits and punctuation keys
// ----------------------------------------------------------------------------
module hk2a_char_lut
   import hk2a_pkg::*;
(
   input  logic [7:0] key_code,
   input  logic       shift,
   output logic [6:0] ascii_char
);

   logic [6:0] letter_off;
   logic [3:0] digit_idx;
   logic [3:0] punct_idx;

   assign letter_off = 7'(key_code - KEY_A);
   assign digit_idx  = 4'(key_code - KEY_1);
   assign punct_idx  = 4'(key_code - KEY_SPACE);

   always_comb begin
      unique case (key_code) inside
         [KEY_A:KEY_Z]: begin
            ascii_char = (shift ? CHAR_UPPER_A : CHAR_LOWER_A) + letter_off;
         end
         [KEY_1:KEY_0]: begin
            ascii_char = shift ? DIGIT_SHIFT[digit_idx] : DIGIT_PLAIN[digit_idx];
         end
         [KEY_SPACE:KEY_SLASH]: begin
            ascii_char = shift ? PUNCT_SHIFT[punct_idx] : PUNCT_PLAIN[punct_idx];
         end
         default: begin
            ascii_char = CHAR_NUL;
         end
      endcase
   end

endmodule

/* design/hk2a_decode.sv */
// ----------------------------------------------------------------------------
// hk2a_decode
// classifies one key report and works out the capslock state after it
// ----------------------------------------------------------------------------
module hk2a_decode
   import hk2a_pkg::*;
(
   input  req_type req,
   input  logic    caps_lock,
   output rsp_type rsp
);

   logic       letter;
   logic       shift;
   logic [6:0] lut_char;

   assign letter = (req.key_code >= KEY_A) && (req.key_code <= KEY_Z);
   assign shift  = (|(req.modifier_bits & SHIFT_MASK)) ^ (letter & caps_lock);

   hk2a_char_lut u_char_lut (
      .key_code   (req.key_code),
      .shift      (shift),
      .ascii_char (lut_char)
   );

   always_comb begin
      rsp.caps_active = caps_lock;
      rsp.ascii_char  = CHAR_NUL;
      unique case (req.key_code)
         KEY_CAPS: begin
            rsp.action      = ACT_NONE;
            rsp.caps_active = ~caps_lock;
         end
         KEY_NONE:      rsp.action = ACT_NONE;
         KEY_BACKSPACE: rsp.action = ACT_BACKSPACE;
         KEY_ENTER:     rsp.action = ACT_ENTER;
         KEY_TAB:       rsp.action = ACT_TAB;
         KEY_DELETE:    rsp.action = ACT_DELETE;
         KEY_LEFT:      rsp.action = ACT_LEFT;
         KEY_RIGHT:     rsp.action = ACT_RIGHT;
         KEY_UP:        rsp.action = ACT_UP;
         KEY_DOWN:      rsp.action = ACT_DOWN;
         default: begin
            rsp.ascii_char = lut_char;
            rsp.action     = (lut_char == CHAR_NUL) ? ACT_UNHANDLED : ACT_CHAR;
         end
      endcase
   end

endmodule

/* dv/tb_hid_key_to_ascii_translator.sv */
// ----------------------------------------------------------------------------
// tb_hid_key_to_ascii_translator
// self-checking bench for the hid key report to us-layout ascii translator
//
// key report beats go in on the req channel and translated beats come back on
// the rsp channel. An in-bench translator with its own capslock flag predicts
// every beat that no directed table row fixes. The table covers the extreme
// values, every editing key, unmapped codes and capslock. Random reports
// follow, biased towards mapped keys. Both sides idle at random, and there is
// one long receiver hold-off and one sender pause until the block has drained.
// ----------------------------------------------------------------------------
module tb_hid_key_to_ascii_translator
   import hk2a_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 90;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTED = 10;

   typedef struct {
      req_type beat;
      bit      fixed;
      rsp_type want;
   } report_entry_type;

   localparam logic [7:0] plain_digits [10] = '{
      "1", "2", "3", "4", "5", "6", "7", "8", "9", "0"
   };
   localparam logic [7:0] shifted_digits [10] = '{
      "!", "@", "#", "$", "%", "^", "&", "*", "(", ")"
   };
   localparam logic [7:0] plain_punct [13] = '{
      " ", "-", "=", "[", "]", "\\", 8'h00, ";", "'", 8'h60, ",", ".", "/"
   };
   localparam logic [7:0] shifted_punct [13] = '{
      " ", "_", "+", "{", "}", "|", 8'h00, ":", "\"", "~", "<", ">", "?"
   };
   localparam logic [7:0] editing_keys [8] = '{
      KEY_BACKSPACE, KEY_ENTER, KEY_TAB, KEY_DELETE,
      KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   report_entry_type fixed_q [$];
   rsp_type          pending_results [$];
   logic             caps_model;
   int               n_sent;
   int               n_results;
   int               n_mismatch;
   int               n_chars;
   int               n_editing;
   int               n_toggles;
   int               n_unhandled;
   bit               gaps_on;
   bit               rsp_random;
   bit               hold_request;

   hid_key_to_ascii_translator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #500000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic rsp_type translate_key(input req_type r, input logic caps);
      rsp_type    o;
      logic       letter;
      logic       shift;
      logic [7:0] c;
      c = 8'h00;
      o.action = ACT_NONE;
      o.ascii_char = CHAR_NUL;
      o.caps_active = caps;
      case (r.key_code)
         KEY_CAPS, KEY_NONE: ;
         KEY_BACKSPACE: o.action = ACT_BACKSPACE;
         KEY_ENTER:     o.action = ACT_ENTER;
         KEY_TAB:       o.action = ACT_TAB;
         KEY_DELETE:    o.action = ACT_DELETE;
         KEY_LEFT:      o.action = ACT_LEFT;
         KEY_RIGHT:     o.action = ACT_RIGHT;
         KEY_UP:        o.action = ACT_UP;
         KEY_DOWN:      o.action = ACT_DOWN;
         default: begin
            letter = (r.key_code >= KEY_A) && (r.key_code <= KEY_Z);
            shift = ((r.modifier_bits & SHIFT_MASK) != 8'h00) ^ (letter && caps);
            if (letter) begin
               c = (shift ? 8'h41 : 8'h61) + (r.key_code - KEY_A);
            end else if (r.key_code >= KEY_1 && r.key_code <= KEY_0) begin
               c = shift ? shifted_digits[r.key_code - KEY_1]
                         : plain_digits[r.key_code - KEY_1];
            end else if (r.key_code >= KEY_SPACE && r.key_code <= KEY_SLASH) begin
               c = shift ? shifted_punct[r.key_code - KEY_SPACE]
                         : plain_punct[r.key_code - KEY_SPACE];
            end
            o.ascii_char = c[6:0];
            o.action = (c == 8'h00) ? ACT_UNHANDLED : ACT_CHAR;
         end
      endcase
      return o;
   endfunction

   function automatic report_entry_type report_row(input logic [7:0] m, input logic [7:0] k,
                                                   input bit f, input logic [3:0] a,
                                                   input logic [6:0] ch, input logic cp);
      report_entry_type e;
      e.beat.modifier_bits = m;
      e.beat.key_code = k;
      e.fixed = f;
      e.want.action = a;
      e.want.ascii_char = ch;
      e.want.caps_active = cp;
      return e;
   endfunction

   function automatic report_entry_type random_report();
      report_entry_type e;
      int               pick;
      pick = $urandom_range(0, 99);
      e.fixed = 1'b0;
      e.want = '0;
      e.beat.modifier_bits = 8'($urandom_range(0, 255));
      if (pick < 45) begin
         e.beat.key_code = 8'($urandom_range(KEY_A, KEY_SLASH));
      end else if (pick < 60) begin
         e.beat.key_code = editing_keys[$urandom_range(0, 7)];
      end else if (pick < 68) begin
         e.beat.key_code = KEY_CAPS;
      end else if (pick < 72) begin
         e.beat.key_code = KEY_NONE;
      end else begin
         e.beat.key_code = 8'($urandom_range(0, 255));
      end
      return e;
   endfunction

   task automatic offer_report(input report_entry_type e);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 18) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      fixed_q.push_back(e);
      req_payload <= e.beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // input side: advance the capslock copy and queue the expected beat
   always @(posedge clock) begin
      report_entry_type e;
      rsp_type          guess;
      if (!reset && req_valid && !req_stall) begin
         if (req_payload.key_code == KEY_CAPS) begin
            caps_model = ~caps_model;
            n_toggles++;
         end
         guess = translate_key(req_payload, caps_model);
         if (fixed_q.size() > 0) begin
            e = fixed_q.pop_front();
            if (e.fixed) guess = e.want;
         end
         case (guess.action)
            ACT_CHAR:      n_chars++;
            ACT_UNHANDLED: n_unhandled++;
            ACT_NONE:      ;
            default:       n_editing++;
         endcase
         pending_results.push_back(guess);
         n_sent++;
      end
   end

   // result side
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTED)
               $display("unexpected rsp beat: action %0d char %h caps %b",
                        rsp_payload.action, rsp_payload.ascii_char, rsp_payload.caps_active);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.action !== want.action ||
                rsp_payload.ascii_char !== want.ascii_char ||
                rsp_payload.caps_active !== want.caps_active) begin
               n_mismatch++;
               if (n_mismatch <= MAX_REPORTED)
                  $display("rsp beat %0d: expected action %0d char %h caps %b, got %0d %h %b",
                           n_results, want.action, want.ascii_char, want.caps_active,
                           rsp_payload.action, rsp_payload.ascii_char,
                           rsp_payload.caps_active);
            end
         end
         n_results++;
      end
   end

   // receiver stall, with one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rsp_random && ($urandom_range(0, 99) < 18);
         end
      end
   end

   initial begin
      report_entry_type table_rows [$];
      caps_model = 1'b0;
      n_sent = 0;
      n_results = 0;
      n_mismatch = 0;
      n_chars = 0;
      n_editing = 0;
      n_toggles = 0;
      n_unhandled = 0;
      gaps_on = 1'b1;
      rsp_random = 1'b1;
      hold_request = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      table_rows = '{
         report_row(8'h00, KEY_NONE,      1'b1, ACT_NONE,      CHAR_NUL, 1'b0),
         report_row(8'hff, KEY_NONE,      1'b1, ACT_NONE,      CHAR_NUL, 1'b0),
         report_row(8'h00, KEY_A,         1'b1, ACT_CHAR,      7'h61,    1'b0),
         report_row(8'h02, KEY_Z,         1'b1, ACT_CHAR,      7'h5A,    1'b0),
         report_row(8'h20, KEY_1,         1'b1, ACT_CHAR,      7'h21,    1'b0),
         report_row(8'hdd, KEY_0,         1'b1, ACT_CHAR,      7'h30,    1'b0),
         report_row(8'h00, KEY_SPACE,     1'b1, ACT_CHAR,      7'h20,    1'b0),
         report_row(8'h22, KEY_SPACE,     1'b1, ACT_CHAR,      7'h20,    1'b0),
         report_row(8'hff, KEY_SLASH,     1'b0, ACT_NONE,      CHAR_NUL, 1'b0),
         report_row(8'h00, 8'h31,         1'b0, ACT_NONE,      CHAR_NUL, 1'b0),
         report_row(8'h00, 8'h32,         1'b1, ACT_UNHANDLED, CHAR_NUL, 1'b0),
         report_row(8'h22, 8'h01,         1'b1, ACT_UNHANDLED, CHAR_NUL, 1'b0),
         report_row(8'h00, 8'h3a,         1'b1, ACT_UNHANDLED, CHAR_NUL, 1'b0),
         report_row(8'hff, 8'hff,         1'b1, ACT_UNHANDLED, CHAR_NUL, 1'b0),
         report_row(8'hff, KEY_BACKSPACE, 1'b1, ACT_BACKSPACE, CHAR_NUL, 1'b0),
         report_row(8'h00, KEY_ENTER,     1'b1, ACT_ENTER,     CHAR_NUL, 1'b0),
         report_row(8'h22, KEY_TAB,       1'b1, ACT_TAB,       CHAR_NUL, 1'b0),
         report_row(8'hff, KEY_DELETE,    1'b1, ACT_DELETE,    CHAR_NUL, 1'b0),
         report_row(8'h00, KEY_LEFT,      1'b1, ACT_LEFT,      CHAR_NUL, 1'b0),
         report_row(8'h02, KEY_RIGHT,     1'b1, ACT_RIGHT,     CHAR_NUL, 1'b0),
         report_row(8'h20, KEY_UP,        1'b1, ACT_UP,        CHAR_NUL, 1'b0),
         report_row(8'h00, KEY_DOWN,      1'b1, ACT_DOWN,      CHAR_NUL, 1'b0),
         report_row(8'h00, KEY_CAPS,      1'b1, ACT_NONE,      CHAR_NUL, 1'b1),
         report_row(8'h00, KEY_A,         1'b1, ACT_CHAR,      7'h41,    1'b1),
         report_row(8'h20, KEY_A,         1'b1, ACT_CHAR,      7'h61,    1'b1),
         report_row(8'h02, KEY_1,         1'b0, ACT_NONE,      CHAR_NUL, 1'b0),
         report_row(8'hff, KEY_CAPS,      1'b1, ACT_NONE,      CHAR_NUL, 1'b0)
      };
      foreach (table_rows[i]) offer_report(table_rows[i]);

      repeat (450) offer_report(random_report());

      // sender pause until the block has drained
      req_valid <= 1'b0;
      @(posedge clock);
      wait (n_results >= n_sent);
      @(posedge clock);

      // back-to-back beats with the receiver always ready
      gaps_on = 1'b0;
      rsp_random = 1'b0;
      repeat (250) offer_report(random_report());

      // long receiver hold-off while beats keep coming
      hold_request = 1'b1;
      repeat (150) offer_report(random_report());
      rsp_random = 1'b1;
      gaps_on = 1'b1;

      repeat (500) offer_report(random_report());

      req_valid <= 1'b0;
      @(posedge clock);
      wait (n_results >= n_sent);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) n_mismatch++;

      $display("sent %0d key reports, checked %0d result beats, %0d mismatches",
               n_sent, n_results, n_mismatch);
      $display("covered %0d characters, %0d editing keys, %0d capslock toggles, %0d unhandled",
               n_chars, n_editing, n_toggles, n_unhandled);
      if (n_mismatch == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
